// ----- hdl/mcl_pkg.sv -----
`default_nettype none
package mcl_pkg;

    localparam int MAX_LINKS     = 16384;
    localparam int MAX_TRIANGLES = 32768;
    localparam int FIELD_BITS    = 32;
    localparam int LINK_AW       = $clog2(MAX_LINKS);
    localparam int TRI_AW        = $clog2(MAX_TRIANGLES);
    localparam int INC_BITS      = 3 * LINK_AW + 3;
    localparam int RES_BITS      = 48;
    localparam int ENERGY_BITS   = 63;
    localparam int GAIN_BITS     = 16;

    localparam logic [2:0] OP_WR_LINK = 3'd0;
    localparam logic [2:0] OP_WR_TRI  = 3'd1;
    localparam logic [2:0] OP_TICK    = 3'd2;
    localparam logic [2:0] OP_RD_LINK = 3'd3;
    localparam logic [2:0] OP_RD_TRI  = 3'd4;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    localparam logic [1:0] CFG_STEP_GAIN  = 2'd0;
    localparam logic [1:0] CFG_LINK_COUNT = 2'd1;
    localparam logic [1:0] CFG_TRI_COUNT  = 2'd2;

    localparam logic [GAIN_BITS-1:0] STEP_GAIN_RESET = 16'd328;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [14:0]        index;
        logic signed [31:0] value;
        logic               probe_flag;
        logic [13:0]        edge_first;
        logic [13:0]        edge_second;
        logic [13:0]        edge_third;
        logic               neg_first;
        logic               neg_second;
        logic               neg_third;
    } t_req;

    typedef struct packed {
        logic               status;
        logic signed [47:0] result_value;
        logic [62:0]        energy;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_WAIT,
        S_LA_RD,
        S_LA_OPS,
        S_LA_MUL,
        S_LA_ACC,
        S_TB_RD,
        S_TB_OPS,
        S_TB_MUL,
        S_TB_ACC,
        S_TC_RD,
        S_TC_CAP,
        S_TC_LK,
        S_TC_LW,
        S_TC_OPS,
        S_TC_MUL,
        S_TC_WR,
        S_TD_RD,
        S_TD_CAP,
        S_TD_MUL,
        S_TD_SC,
        S_TD_LK,
        S_TD_LW
    } t_state;

endpackage
`default_nettype wire

// ----- hdl/mcl_ram.sv -----
`default_nettype none
module mcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- hdl/mesh_curl_leapfrog_step_top.sv -----
`default_nettype none
// Leapfrog curl step over a triangle mesh. Pulse i_start with a request while o_busy is low;
// exactly one response comes back on o_rsp with o_strobe high for one cycle, and it cannot
// be held off. Link and triangle loads answer straight from idle, readbacks through a wait
// state. A tick sweeps the links once and the triangles three times: energy, curl update
// and edge scatter. All passes share one multiplier and the single read port of the link
// memory. The response of a tick carries the probe sum and half energy of the state before
// the update. Write configuration only while the block is idle.
module mesh_curl_leapfrog_step_top
    import mcl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire t_req        i_req,
    output logic             o_strobe,
    output t_rsp             o_rsp,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_state r_state, n_state;
    logic [15:0] r_i, n_i;
    logic [14:0] r_nl, n_nl;
    logic [15:0] r_nt, n_nt;
    logic [1:0]  r_k, n_k;
    logic signed [47:0] r_psum, n_psum;
    logic [62:0] r_energy, n_energy;
    logic signed [33:0] r_circ, n_circ;
    logic r_sgn, n_sgn;
    logic [33:0] r_mul_a, n_mul_a;
    logic [31:0] r_mul_b, n_mul_b;
    logic [63:0] r_prod;
    logic [INC_BITS-1:0] r_inc, n_inc;
    logic signed [31:0] r_tv, n_tv;
    logic signed [32:0] r_b, n_b;
    logic r_rd_tri, n_rd_tri;
    logic r_strobe, n_strobe;
    t_rsp r_rsp, n_rsp;
    logic [GAIN_BITS-1:0] r_gain;
    logic [14:0] r_link_count;
    logic [15:0] r_tri_count;

    logic                lk_we;
    logic [LINK_AW-1:0]  lk_waddr, lk_raddr;
    logic [32:0]         lk_wdata, lk_q;
    logic                tv_we;
    logic [TRI_AW-1:0]   tv_waddr, tv_raddr;
    logic [31:0]         tv_wdata, tv_q;
    logic                inc_we;
    logic [INC_BITS-1:0] inc_wdata, inc_q;

    logic signed [31:0] lk_val;
    logic               lk_probe;
    logic [13:0]        cur_edge;
    logic               cur_neg;

    function automatic logic signed [31:0] sat_field(input logic signed [35:0] x);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sh07FFFFFFF;
        lo = -36'sh080000000;
        if (x > hi) begin
            return 32'sh7FFFFFFF;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] u;
        u = v;
        return v[31] ? (32'd0 - u) : u;
    endfunction

    mcl_ram #(.WIDTH(33), .DEPTH(MAX_LINKS)) u_link_ram (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_waddr), .i_wdata(lk_wdata),
        .i_raddr(lk_raddr), .o_rdata(lk_q)
    );

    mcl_ram #(.WIDTH(32), .DEPTH(MAX_TRIANGLES)) u_tri_ram (
        .i_clk(i_clk), .i_we(tv_we), .i_waddr(tv_waddr), .i_wdata(tv_wdata),
        .i_raddr(tv_raddr), .o_rdata(tv_q)
    );

    mcl_ram #(.WIDTH(INC_BITS), .DEPTH(MAX_TRIANGLES)) u_inc_ram (
        .i_clk(i_clk), .i_we(inc_we), .i_waddr(tv_waddr), .i_wdata(inc_wdata),
        .i_raddr(tv_raddr), .o_rdata(inc_q)
    );

    assign lk_val   = $signed(lk_q[31:0]);
    assign lk_probe = lk_q[32];

    // incidence word: {neg third, neg second, neg first, third, second, first}
    always_comb begin
        unique case (r_k)
            2'd0: begin
                cur_edge = r_inc[LINK_AW-1:0];
                cur_neg  = r_inc[3*LINK_AW];
            end
            2'd1: begin
                cur_edge = r_inc[2*LINK_AW-1:LINK_AW];
                cur_neg  = r_inc[3*LINK_AW+1];
            end
            default: begin
                cur_edge = r_inc[3*LINK_AW-1:2*LINK_AW];
                cur_neg  = r_inc[3*LINK_AW+2];
            end
        endcase
    end

    always_comb begin
        logic signed [48:0] psum_x;
        logic [63:0]        e_sum;
        logic [31:0]        mag;
        logic [33:0]        rnd;
        logic signed [35:0] tsum;
        logic signed [33:0] lsum;
        logic signed [33:0] term;

        psum_x = '0;
        e_sum  = '0;
        mag    = '0;
        rnd    = 34'((r_prod + 64'h8000) >> 16);
        tsum   = '0;
        lsum   = '0;
        term   = '0;

        n_state  = r_state;
        n_i      = r_i;
        n_nl     = r_nl;
        n_nt     = r_nt;
        n_k      = r_k;
        n_psum   = r_psum;
        n_energy = r_energy;
        n_circ   = r_circ;
        n_sgn    = r_sgn;
        n_mul_a  = r_mul_a;
        n_mul_b  = r_mul_b;
        n_inc    = r_inc;
        n_tv     = r_tv;
        n_b      = r_b;
        n_rd_tri = r_rd_tri;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;

        lk_we     = 1'b0;
        lk_waddr  = cur_edge;
        lk_wdata  = {i_req.probe_flag, i_req.value};
        lk_raddr  = r_i[LINK_AW-1:0];
        tv_we     = 1'b0;
        tv_waddr  = r_i[TRI_AW-1:0];
        tv_wdata  = i_req.value;
        tv_raddr  = r_i[TRI_AW-1:0];
        inc_we    = 1'b0;
        inc_wdata = {i_req.neg_third, i_req.neg_second, i_req.neg_first,
                     i_req.edge_third, i_req.edge_second, i_req.edge_first};

        unique case (r_state)
            S_IDLE: begin
                lk_raddr = i_req.index[LINK_AW-1:0];
                tv_raddr = i_req.index[TRI_AW-1:0];
                tv_waddr = i_req.index[TRI_AW-1:0];
                lk_waddr = i_req.index[LINK_AW-1:0];
                if (i_start) begin
                    n_rsp = '0;
                    unique case (i_req.opcode)
                        OP_WR_LINK: begin
                            if (32'(i_req.index) >= MAX_LINKS) begin
                                n_rsp.status = ST_RANGE;
                            end else begin
                                lk_we = 1'b1;
                            end
                            n_strobe = 1'b1;
                        end
                        OP_WR_TRI: begin
                            if (32'(i_req.index) >= MAX_TRIANGLES
                                || 32'(i_req.edge_first) >= MAX_LINKS
                                || 32'(i_req.edge_second) >= MAX_LINKS
                                || 32'(i_req.edge_third) >= MAX_LINKS) begin
                                n_rsp.status = ST_RANGE;
                            end else begin
                                tv_we  = 1'b1;
                                inc_we = 1'b1;
                            end
                            n_strobe = 1'b1;
                        end
                        OP_RD_LINK: begin
                            if (32'(i_req.index) >= MAX_LINKS) begin
                                n_rsp.status = ST_RANGE;
                                n_strobe     = 1'b1;
                            end else begin
                                n_rd_tri = 1'b0;
                                n_state  = S_RD_WAIT;
                            end
                        end
                        OP_RD_TRI: begin
                            if (32'(i_req.index) >= MAX_TRIANGLES) begin
                                n_rsp.status = ST_RANGE;
                                n_strobe     = 1'b1;
                            end else begin
                                n_rd_tri = 1'b1;
                                n_state  = S_RD_WAIT;
                            end
                        end
                        OP_TICK: begin
                            n_nl = (32'(r_link_count) > MAX_LINKS) ?
                                   15'(MAX_LINKS) : r_link_count;
                            n_nt = (32'(r_tri_count) > MAX_TRIANGLES) ?
                                   16'(MAX_TRIANGLES) : r_tri_count;
                            n_i      = '0;
                            n_psum   = '0;
                            n_energy = '0;
                            n_state  = S_LA_RD;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_rsp.result_value = r_rd_tri ? 48'($signed(tv_q)) : 48'(lk_val);
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_LA_RD: begin
                if (r_i == 16'(r_nl)) begin
                    n_i     = '0;
                    n_state = S_TB_RD;
                end else begin
                    n_state = S_LA_OPS;
                end
            end
            S_LA_OPS: begin
                mag     = mag32(lk_val);
                n_mul_a = 34'(mag);
                n_mul_b = mag;
                if (lk_probe) begin
                    psum_x = 49'(r_psum) + 49'(lk_val);
                    if (psum_x[48] != psum_x[47]) begin
                        n_psum = psum_x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                    end else begin
                        n_psum = psum_x[47:0];
                    end
                end
                n_state = S_LA_MUL;
            end
            S_LA_MUL: begin
                n_state = S_LA_ACC;
            end
            S_LA_ACC: begin
                e_sum    = {1'b0, r_energy} + 64'(r_prod[63:33]);
                n_energy = e_sum[63] ? {ENERGY_BITS{1'b1}} : e_sum[62:0];
                n_i      = r_i + 16'd1;
                n_state  = S_LA_RD;
            end
            S_TB_RD: begin
                if (r_i == r_nt) begin
                    n_i     = '0;
                    n_state = S_TC_RD;
                end else begin
                    n_state = S_TB_OPS;
                end
            end
            S_TB_OPS: begin
                mag     = mag32($signed(tv_q));
                n_mul_a = 34'(mag);
                n_mul_b = mag;
                n_state = S_TB_MUL;
            end
            S_TB_MUL: begin
                n_state = S_TB_ACC;
            end
            S_TB_ACC: begin
                e_sum    = {1'b0, r_energy} + 64'(r_prod[63:33]);
                n_energy = e_sum[63] ? {ENERGY_BITS{1'b1}} : e_sum[62:0];
                n_i      = r_i + 16'd1;
                n_state  = S_TB_RD;
            end
            S_TC_RD: begin
                if (r_i == r_nt) begin
                    n_i     = '0;
                    n_state = S_TD_RD;
                end else begin
                    n_state = S_TC_CAP;
                end
            end
            S_TC_CAP: begin
                n_inc   = inc_q;
                n_tv    = $signed(tv_q);
                n_k     = '0;
                n_circ  = '0;
                n_state = S_TC_LK;
            end
            S_TC_LK: begin
                lk_raddr = cur_edge;
                n_state  = S_TC_LW;
            end
            S_TC_LW: begin
                term   = cur_neg ? -34'(lk_val) : 34'(lk_val);
                n_circ = r_circ + term;
                if (r_k == 2'd2) begin
                    n_state = S_TC_OPS;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_TC_LK;
                end
            end
            S_TC_OPS: begin
                n_sgn   = r_circ[33];
                n_mul_a = r_circ[33] ? 34'(-r_circ) : 34'(r_circ);
                n_mul_b = 32'(r_gain);
                n_state = S_TC_MUL;
            end
            S_TC_MUL: begin
                n_state = S_TC_WR;
            end
            S_TC_WR: begin
                // subtract the rounded, scaled circulation and saturate
                tsum     = r_sgn ? (36'(r_tv) + 36'(rnd)) : (36'(r_tv) - 36'(rnd));
                tv_we    = 1'b1;
                tv_wdata = sat_field(tsum);
                n_i      = r_i + 16'd1;
                n_state  = S_TC_RD;
            end
            S_TD_RD: begin
                if (r_i == r_nt) begin
                    n_rsp.status       = ST_OK;
                    n_rsp.result_value = r_psum;
                    n_rsp.energy       = r_energy;
                    n_strobe           = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    n_state = S_TD_CAP;
                end
            end
            S_TD_CAP: begin
                n_inc   = inc_q;
                n_sgn   = tv_q[31];
                n_mul_a = 34'(mag32($signed(tv_q)));
                n_mul_b = 32'(r_gain);
                n_k     = '0;
                n_state = S_TD_MUL;
            end
            S_TD_MUL: begin
                n_state = S_TD_SC;
            end
            S_TD_SC: begin
                n_b     = r_sgn ? -33'(rnd) : 33'(rnd);
                n_state = S_TD_LK;
            end
            S_TD_LK: begin
                lk_raddr = cur_edge;
                n_state  = S_TD_LW;
            end
            S_TD_LW: begin
                // read-modify-write; the next edge reads after this write lands
                lsum     = cur_neg ? (34'(lk_val) - 34'(r_b)) : (34'(lk_val) + 34'(r_b));
                lk_we    = 1'b1;
                lk_waddr = cur_edge;
                lk_wdata = {lk_probe, sat_field(36'(lsum))};
                if (r_k == 2'd2) begin
                    n_i     = r_i + 16'd1;
                    n_state = S_TD_RD;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_TD_LK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strobe     <= 1'b0;
            r_gain       <= STEP_GAIN_RESET;
            r_link_count <= '0;
            r_tri_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_STEP_GAIN:  r_gain       <= i_cfg_data;
                    CFG_LINK_COUNT: r_link_count <= i_cfg_data[14:0];
                    CFG_TRI_COUNT:  r_tri_count  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_nl     <= n_nl;
        r_nt     <= n_nt;
        r_k      <= n_k;
        r_psum   <= n_psum;
        r_energy <= n_energy;
        r_circ   <= n_circ;
        r_sgn    <= n_sgn;
        r_mul_a  <= n_mul_a;
        r_mul_b  <= n_mul_b;
        r_prod   <= 64'(r_mul_a * r_mul_b);
        r_inc    <= n_inc;
        r_tv     <= n_tv;
        r_b      <= n_b;
        r_rd_tri <= n_rd_tri;
        r_rsp    <= n_rsp;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire
